// File: hw/rtl/mft_pkg.sv
// Package for the recursive FIFO monitor table: sizes, derived widths,
// operation and status codes, controller states and a small helper.
// No dependencies; used by the top level, recursive_fifo_monitor_table.
`default_nettype none

package mft_pkg;

  localparam int MONITORS    = 16;
  localparam int QUEUE_DEPTH = 8;

  localparam int MON_W  = (MONITORS > 1) ? $clog2(MONITORS) : 1;
  localparam int Q_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QLEN_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QA_W   = MON_W + Q_W;
  localparam int QRAM_DEPTH = 1 << QA_W;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] MODE_ENTER   = 3'd0;
  localparam logic [2:0] MODE_EXIT    = 3'd1;
  localparam logic [2:0] MODE_RELEASE = 3'd2;
  localparam logic [2:0] MODE_SNAP    = 3'd3;
  localparam logic [2:0] MODE_CLEAR   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BLOCK     = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_ILLEGAL   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;
  localparam logic [2:0] ST_CANCELLED = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DISPATCH,
    S_DECIDE,
    S_WALK_RD,
    S_WALK_CHK,
    S_AFTER_WALK,
    S_RA_ENTRY,
    S_RA_HEAD,
    S_RA_FREE,
    S_RA_NEXT,
    S_EMIT
  } st_t;

  // Queue length as reported on the four-bit waiters field, saturated at 15.
  function automatic logic [3:0] sat_waiters(input logic [QLEN_W-1:0] q);
    int v;
    v = int'(q);
    return (v > 15) ? 4'hF : 4'(v);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mft_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No dependencies.
`default_nettype none

module mft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/recursive_fifo_monitor_table.sv
// Top level of the recursive FIFO monitor table: controller, per-entry
// flags and the object, count and queue memories.
// Depends on mft_pkg and mft_ram.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+---------------------------------------------
//   in      | in_valid/in_ready  | mode, object_id, req_thread
//   out     | out_valid/out_ready| status, wake_valid, wake_tid, owner,
//           |                    | recursion, waiters, last
//
// Enter, exit and snapshot scan the object memory once they are accepted,
// then decide on the entry they found; enter may also walk the entry queue.
// Release-all visits every entry in turn, walks each non-empty queue, and
// gives one transaction per wake.
// Clear and rejected requests skip the scan and answer directly.
// Reset is synchronous; it empties the table and clears the cancelled flag.
// The object and queue memories need no clearing pass: valid bits and queue
// lengths guard every read. A waiting result sits in the output register, so
// a new request is taken while the consumer stalls.
`default_nettype none

module recursive_fifo_monitor_table
  import mft_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  mode,
  input  wire logic [63:0] object_id,
  input  wire logic [7:0]  req_thread,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic             wake_valid,
  output logic [7:0]       wake_tid,
  output logic [7:0]       owner,
  output logic [31:0]      recursion,
  output logic [3:0]       waiters,
  output logic             last
);

  // Controller state.
  st_t state, state_next;

  // Per-entry flags kept in flip-flops, since their reset values matter.
  logic [MONITORS-1:0] ent_valid, ent_valid_next;
  logic [7:0]          ent_owner [MONITORS];
  logic [7:0]          ent_owner_next [MONITORS];
  logic [QLEN_W-1:0]   ent_qlen [MONITORS];
  logic [QLEN_W-1:0]   ent_qlen_next [MONITORS];
  logic                cancelled, cancelled_next;

  // The current transaction.
  logic [2:0]  op, op_next;
  logic [63:0] obj, obj_next;
  logic [7:0]  tid, tid_next;
  logic [MON_W-1:0] idx, idx_next;

  // Object scan.
  logic [MON_W:0]   scan_pos, scan_pos_next;
  logic             cmp_pend, cmp_pend_next;
  logic [MON_W-1:0] cmp_idx, cmp_idx_next;
  logic             hit, hit_next;
  logic [MON_W-1:0] hit_idx, hit_idx_next;
  logic             free_found, free_found_next;
  logic [MON_W-1:0] free_idx, free_idx_next;

  // Queue walk: wpos reads, wn writes the compacted queue.
  logic [QLEN_W-1:0] wpos, wpos_next;
  logic [QLEN_W-1:0] wn, wn_next;
  logic              whas, whas_next;
  logic              wremove, wremove_next;
  logic              ra_rel, ra_rel_next;

  // Pending result.
  logic [2:0]  r_status, r_status_next;
  logic        r_wv, r_wv_next;
  logic [7:0]  r_wt, r_wt_next;
  logic [7:0]  r_owner, r_owner_next;
  logic [31:0] r_rec, r_rec_next;
  logic [3:0]  r_wait, r_wait_next;
  logic        r_last, r_last_next;

  // Output register.
  logic        out_valid_next;
  logic [2:0]  status_next;
  logic        wake_valid_next;
  logic [7:0]  wake_tid_next;
  logic [7:0]  owner_next;
  logic [31:0] recursion_next;
  logic [3:0]  waiters_next;
  logic        last_next;

  // Memory ports.
  logic             obj_we;
  logic [MON_W-1:0] obj_waddr, obj_raddr;
  logic [63:0]      obj_rdata;
  logic             cnt_we;
  logic [MON_W-1:0] cnt_waddr, cnt_raddr;
  logic [31:0]      cnt_wdata, cnt_rdata;
  logic             q_we;
  logic [QA_W-1:0]  q_waddr, q_raddr;
  logic [7:0]       q_wdata, q_rdata;

  logic [7:0]        cur_owner;
  logic [QLEN_W-1:0] cur_qlen;

  assign in_ready  = (state == S_IDLE);
  assign cur_owner = ent_owner[idx];
  assign cur_qlen  = ent_qlen[idx];

  mft_ram #(.WIDTH(64), .DEPTH(MONITORS)) u_obj_ram (
    .clk(clk), .we(obj_we), .waddr(obj_waddr), .wdata(obj),
    .raddr(obj_raddr), .rdata(obj_rdata)
  );

  mft_ram #(.WIDTH(32), .DEPTH(MONITORS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  mft_ram #(.WIDTH(8), .DEPTH(QRAM_DEPTH)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  always_comb begin
    state_next      = state;
    ent_valid_next  = ent_valid;
    ent_owner_next  = ent_owner;
    ent_qlen_next   = ent_qlen;
    cancelled_next  = cancelled;
    op_next         = op;
    obj_next        = obj;
    tid_next        = tid;
    idx_next        = idx;
    scan_pos_next   = scan_pos;
    cmp_pend_next   = cmp_pend;
    cmp_idx_next    = cmp_idx;
    hit_next        = hit;
    hit_idx_next    = hit_idx;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    wpos_next       = wpos;
    wn_next         = wn;
    whas_next       = whas;
    wremove_next    = wremove;
    ra_rel_next     = ra_rel;
    r_status_next   = r_status;
    r_wv_next       = r_wv;
    r_wt_next       = r_wt;
    r_owner_next    = r_owner;
    r_rec_next      = r_rec;
    r_wait_next     = r_wait;
    r_last_next     = r_last;

    out_valid_next  = out_valid && !out_ready;
    status_next     = status;
    wake_valid_next = wake_valid;
    wake_tid_next   = wake_tid;
    owner_next      = owner;
    recursion_next  = recursion;
    waiters_next    = waiters;
    last_next       = last;

    obj_we    = 1'b0;
    obj_waddr = free_idx;
    obj_raddr = scan_pos[MON_W-1:0];
    cnt_we    = 1'b0;
    cnt_waddr = idx;
    cnt_wdata = 32'd0;
    cnt_raddr = idx;
    q_we      = 1'b0;
    q_waddr   = {idx, wn[Q_W-1:0]};
    q_wdata   = q_rdata;
    q_raddr   = {idx, wpos[Q_W-1:0]};

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next       = mode;
          obj_next      = object_id;
          tid_next      = req_thread;
          r_status_next = ST_OK;
          r_wv_next     = 1'b0;
          r_wt_next     = 8'd0;
          r_owner_next  = 8'd0;
          r_rec_next    = 32'd0;
          r_wait_next   = 4'd0;
          r_last_next   = 1'b1;
          scan_pos_next   = '0;
          cmp_pend_next   = 1'b0;
          hit_next        = 1'b0;
          free_found_next = 1'b0;
          case (mode)
            MODE_ENTER: begin
              if (object_id == 64'd0 || req_thread == 8'd0) begin
                r_status_next = ST_INVALID;
                state_next    = S_EMIT;
              end else if (cancelled) begin
                r_status_next = ST_CANCELLED;
                state_next    = S_EMIT;
              end else begin
                state_next = S_SCAN;
              end
            end
            MODE_EXIT, MODE_SNAP: begin
              if (object_id == 64'd0) begin
                r_status_next = ST_INVALID;
                state_next    = S_EMIT;
              end else begin
                state_next = S_SCAN;
              end
            end
            MODE_RELEASE: begin
              if (req_thread == 8'd0) begin
                r_status_next = ST_INVALID;
                state_next    = S_EMIT;
              end else begin
                idx_next   = '0;
                state_next = S_RA_ENTRY;
              end
            end
            MODE_CLEAR: begin
              for (int i = 0; i < MONITORS; i++) begin
                ent_valid_next[i] = 1'b0;
                ent_owner_next[i] = 8'd0;
                ent_qlen_next[i]  = '0;
              end
              cancelled_next = 1'b1;
              state_next     = S_EMIT;
            end
            default: begin
              r_status_next = ST_INVALID;
              state_next    = S_EMIT;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (cmp_pend) begin
          if (ent_valid[cmp_idx] && obj_rdata == obj && !hit) begin
            hit_next     = 1'b1;
            hit_idx_next = cmp_idx;
          end
          if (!ent_valid[cmp_idx] && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = cmp_idx;
          end
        end
        if (scan_pos == (MON_W + 1)'(MONITORS)) begin
          cmp_pend_next = 1'b0;
          state_next    = S_DISPATCH;
        end else begin
          cmp_pend_next = 1'b1;
          cmp_idx_next  = scan_pos[MON_W-1:0];
          scan_pos_next = scan_pos + 1'b1;
        end
      end

      S_DISPATCH: begin
        cnt_raddr = hit_idx;
        q_raddr   = {hit_idx, Q_W'(0)};
        if (hit) begin
          idx_next   = hit_idx;
          state_next = S_DECIDE;
        end else begin
          state_next = S_EMIT;
          case (op)
            MODE_ENTER: begin
              if (free_found) begin
                ent_valid_next[free_idx] = 1'b1;
                ent_owner_next[free_idx] = tid;
                ent_qlen_next[free_idx]  = '0;
                obj_we    = 1'b1;
                cnt_we    = 1'b1;
                cnt_waddr = free_idx;
                cnt_wdata = 32'd1;
              end else begin
                r_status_next = ST_FULL;
              end
            end
            MODE_EXIT: r_status_next = ST_ILLEGAL;
            default:   r_status_next = ST_OK;
          endcase
        end
      end

      S_DECIDE: begin
        state_next = S_EMIT;
        case (op)
          MODE_ENTER: begin
            wpos_next = '0;
            wn_next   = '0;
            whas_next = 1'b0;
            if (cur_owner == 8'd0 && (cur_qlen == '0 || q_rdata == tid)) begin
              ent_owner_next[idx] = tid;
              cnt_we    = 1'b1;
              cnt_wdata = 32'd1;
              if (cur_qlen != '0) begin
                wremove_next = 1'b1;
                state_next   = S_WALK_RD;
              end
            end else if (cur_owner == tid) begin
              if (cnt_rdata == COUNT_MAX) begin
                r_status_next = ST_OVERFLOW;
              end else begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_rdata + 32'd1;
              end
            end else begin
              wremove_next = 1'b0;
              state_next   = S_WALK_RD;
            end
          end
          MODE_EXIT: begin
            if (cur_owner != tid || cnt_rdata == 32'd0) begin
              r_status_next = ST_ILLEGAL;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_rdata - 32'd1;
              if (cnt_rdata == 32'd1) begin
                ent_owner_next[idx] = 8'd0;
                if (cur_qlen != '0) begin
                  r_wv_next = 1'b1;
                  r_wt_next = q_rdata;
                end else begin
                  ent_valid_next[idx] = 1'b0;
                end
              end
            end
          end
          default: begin
            r_owner_next = cur_owner;
            r_rec_next   = cnt_rdata;
            r_wait_next  = sat_waiters(cur_qlen);
          end
        endcase
      end

      S_WALK_RD: begin
        if (wpos == cur_qlen) begin
          state_next = S_AFTER_WALK;
        end else begin
          state_next = S_WALK_CHK;
        end
      end

      S_WALK_CHK: begin
        if (q_rdata == tid) begin
          whas_next = 1'b1;
        end else if (wremove) begin
          q_we    = 1'b1;
          wn_next = wn + 1'b1;
        end
        wpos_next  = wpos + 1'b1;
        state_next = S_WALK_RD;
      end

      S_AFTER_WALK: begin
        q_raddr = {idx, Q_W'(0)};
        if (op == MODE_RELEASE) begin
          ent_qlen_next[idx] = wn;
          state_next = (ra_rel && wn != '0) ? S_RA_HEAD : S_RA_FREE;
        end else if (wremove) begin
          ent_qlen_next[idx] = wn;
          state_next = S_EMIT;
        end else begin
          state_next    = S_EMIT;
          r_status_next = ST_BLOCK;
          if (!whas) begin
            if (cur_qlen >= QLEN_W'(QUEUE_DEPTH)) begin
              r_status_next = ST_FULL;
            end else begin
              q_we    = 1'b1;
              q_waddr = {idx, cur_qlen[Q_W-1:0]};
              q_wdata = tid;
              ent_qlen_next[idx] = cur_qlen + 1'b1;
            end
          end
        end
      end

      S_RA_ENTRY: begin
        if (!ent_valid[idx]) begin
          state_next = S_RA_NEXT;
        end else begin
          ra_rel_next = (cur_owner == tid);
          if (cur_owner == tid) begin
            ent_owner_next[idx] = 8'd0;
            cnt_we    = 1'b1;
            cnt_wdata = 32'd0;
          end
          wpos_next    = '0;
          wn_next      = '0;
          whas_next    = 1'b0;
          wremove_next = 1'b1;
          state_next   = (cur_qlen != '0) ? S_WALK_RD : S_RA_FREE;
        end
      end

      S_RA_HEAD: begin
        // The released entry still has waiters, so it stays allocated.
        r_status_next = ST_OK;
        r_wv_next     = 1'b1;
        r_wt_next     = q_rdata;
        r_owner_next  = 8'd0;
        r_rec_next    = 32'd0;
        r_wait_next   = 4'd0;
        r_last_next   = 1'b0;
        state_next    = S_EMIT;
      end

      S_RA_FREE: begin
        if (cur_owner == 8'd0 && cur_qlen == '0) begin
          ent_valid_next[idx] = 1'b0;
        end
        state_next = S_RA_NEXT;
      end

      S_RA_NEXT: begin
        if (idx == MON_W'(MONITORS - 1)) begin
          r_status_next = ST_OK;
          r_wv_next     = 1'b0;
          r_wt_next     = 8'd0;
          r_owner_next  = 8'd0;
          r_rec_next    = 32'd0;
          r_wait_next   = 4'd0;
          r_last_next   = 1'b1;
          state_next    = S_EMIT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_RA_ENTRY;
        end
      end

      S_EMIT: begin
        if (!out_valid || out_ready) begin
          out_valid_next  = 1'b1;
          status_next     = r_status;
          wake_valid_next = r_wv;
          wake_tid_next   = r_wt;
          owner_next      = r_owner;
          recursion_next  = r_rec;
          waiters_next    = r_wait;
          last_next       = r_last;
          state_next      = r_last ? S_IDLE : S_RA_NEXT;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ent_valid <= '0;
      for (int i = 0; i < MONITORS; i++) begin
        ent_owner[i] <= 8'd0;
        ent_qlen[i]  <= '0;
      end
      cancelled <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state     <= state_next;
      ent_valid <= ent_valid_next;
      ent_owner <= ent_owner_next;
      ent_qlen  <= ent_qlen_next;
      cancelled <= cancelled_next;
      out_valid <= out_valid_next;
      idx       <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    op          <= op_next;
    obj         <= obj_next;
    tid         <= tid_next;
    scan_pos    <= scan_pos_next;
    cmp_pend    <= cmp_pend_next;
    cmp_idx     <= cmp_idx_next;
    hit         <= hit_next;
    hit_idx     <= hit_idx_next;
    free_found  <= free_found_next;
    free_idx    <= free_idx_next;
    wpos        <= wpos_next;
    wn          <= wn_next;
    whas        <= whas_next;
    wremove     <= wremove_next;
    ra_rel      <= ra_rel_next;
    r_status    <= r_status_next;
    r_wv        <= r_wv_next;
    r_wt        <= r_wt_next;
    r_owner     <= r_owner_next;
    r_rec       <= r_rec_next;
    r_wait      <= r_wait_next;
    r_last      <= r_last_next;
    status      <= status_next;
    wake_valid  <= wake_valid_next;
    wake_tid    <= wake_tid_next;
    owner       <= owner_next;
    recursion   <= recursion_next;
    waiters     <= waiters_next;
    last        <= last_next;
  end

  // A queue never grows beyond its depth.
  a_qlen_bound: assert property (@(posedge clk) disable iff (rst)
    cur_qlen <= QLEN_W'(QUEUE_DEPTH))
    else $error("entry queue length beyond depth");

  // Once the table is cleared it stays cancelled until reset.
  a_cancel_sticky: assert property (@(posedge clk) disable iff (rst)
    cancelled |=> cancelled)
    else $error("cancelled flag dropped without reset");

  // Compaction never writes ahead of the slot being read.
  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK_CHK |-> wn <= wpos)
    else $error("queue compaction overtook the read pointer");

  // Release-all drops the ownership of the visited entry in the next cycle.
  a_release_drop: assert property (@(posedge clk) disable iff (rst)
    (state == S_RA_ENTRY && ent_valid[idx] && cur_owner == tid)
      |=> cur_owner == 8'd0)
    else $error("release-all kept an owned entry");

endmodule

`default_nettype wire
